// ----- design/spdd_pkg.sv -----
// Shared types and constants for the stick pulse deadzone dither block.
// No dependencies; used by every module of the block.
package spdd_pkg;

    localparam int DUTY_BITS_DEF = 14;
    localparam int PW            = 14;
    localparam int NCH           = 4;

    localparam logic [1:0] OP_AUTO = 2'd0;
    localparam logic [1:0] OP_RX   = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_LOAD = 2'd3;

    localparam logic [2:0] REG_AUTO_MASK    = 3'd0;
    localparam logic [2:0] REG_PULSE_LOW    = 3'd1;
    localparam logic [2:0] REG_PULSE_HIGH   = 3'd2;
    localparam logic [2:0] REG_PULSE_MIDDLE = 3'd3;
    localparam logic [2:0] REG_EDGE_ABOVE   = 3'd4;
    localparam logic [2:0] REG_EDGE_BELOW   = 3'd5;
    localparam logic [2:0] REG_DITHER_SPAN  = 3'd6;

    localparam int STICK_FULL = 10000;
    localparam int STICK_DEAD = 1000;
    localparam int FRAC_ONE   = 1000;

    // |num| / 20000 == ((|num| >> 5) * RECIP_625) >> RECIP_SHIFT, exact below 2^29
    localparam int          PRE_SHIFT   = 5;
    localparam int          RECIP_SHIFT = 34;
    localparam logic [24:0] RECIP_625   = 25'd27487791;

    localparam logic [13:0] RST_PULSE_LOW    = 14'd9240;
    localparam logic [13:0] RST_PULSE_HIGH   = 14'd15960;
    localparam logic [13:0] RST_PULSE_MIDDLE = 14'd12600;
    localparam logic [13:0] RST_EDGE_ABOVE   = 14'd12969;
    localparam logic [13:0] RST_EDGE_BELOW   = 14'd12230;
    localparam logic [5:0]  RST_DITHER_SPAN  = 6'd50;

    typedef struct packed {
        logic [3:0]  auto_mask;
        logic [13:0] pulse_low;
        logic [13:0] pulse_high;
        logic [13:0] pulse_middle;
        logic [13:0] edge_above;
        logic [13:0] edge_below;
        logic [5:0]  dither_span;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  channel;
        logic [31:0] timeout_value;
        logic [15:0] stick_value;
    } item_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  channel;
        logic [31:0] timeout_value;
        logic [28:0] prod_mag;
        logic        prod_neg;
        logic        stick_neg;
        logic        dead;
        logic [9:0]  frac;
    } map_t;

    typedef struct packed {
        logic                   expired;
        logic [31:0]            ticks_left;
        logic [NCH-1:0][PW-1:0] duty;
    } res_t;

    function automatic logic [15:0] sat16(input logic [15:0] v, input logic [15:0] vmax);
        return (v > vmax) ? vmax : v;
    endfunction

endpackage

// ----- design/spdd_stick_map.sv -----
// Input stage logic: clamps the stick value, forms the mapping product,
// derives the deadzone flag and dither fraction. Depends on spdd_pkg.
module spdd_stick_map (
    input  spdd_pkg::item_t item,
    input  spdd_pkg::cfg_t  cfg,
    output spdd_pkg::map_t  map
);

    logic signed [15:0] s;
    logic signed [15:0] sc;
    logic signed [15:0] off;
    logic signed [14:0] diff;
    logic signed [30:0] prod;
    logic [13:0]        mag;

    always_comb begin
        s = $signed(item.stick_value);
        if (s < -16'(spdd_pkg::STICK_FULL)) begin
            sc = -16'(spdd_pkg::STICK_FULL);
        end else if (s > 16'(spdd_pkg::STICK_FULL)) begin
            sc = 16'(spdd_pkg::STICK_FULL);
        end else begin
            sc = s;
        end
        off  = sc + 16'(spdd_pkg::STICK_FULL);
        diff = $signed({1'b0, cfg.pulse_high}) - $signed({1'b0, cfg.pulse_low});
        prod = 31'(off) * 31'(diff);
        mag  = sc[15] ? 14'(-sc) : 14'(sc);

        map.opcode        = item.opcode;
        map.channel       = item.channel;
        map.timeout_value = item.timeout_value;
        map.prod_neg      = prod[30];
        map.prod_mag      = prod[30] ? 29'(-prod) : 29'(prod);
        map.stick_neg     = sc[15];
        map.dead          = (mag < 14'(spdd_pkg::STICK_DEAD));
        map.frac          = (mag > 14'(spdd_pkg::STICK_DEAD)) ? 10'(spdd_pkg::FRAC_ONE)
                                                              : mag[9:0];
    end

endmodule

// ----- design/spdd_target_calc.sv -----
// Second stage logic: divides the mapping product by the stick span and
// picks the deadzone edge. Depends on spdd_pkg.
module spdd_target_calc #(
    parameter int DUTY_BITS = spdd_pkg::DUTY_BITS_DEF
) (
    input  spdd_pkg::map_t        map,
    input  spdd_pkg::cfg_t        cfg,
    output logic [DUTY_BITS-1:0]  target
);

    localparam logic [15:0] DMAX = 16'((32'd1 << DUTY_BITS) - 32'd1);

    logic [23:0]        pre;
    logic [48:0]        qprod;
    logic [14:0]        quot;
    logic signed [15:0] qs;
    logic signed [15:0] mapped;
    logic [15:0]        pos;

    always_comb begin
        pre   = map.prod_mag[28:spdd_pkg::PRE_SHIFT];
        qprod = 49'(pre) * 49'(spdd_pkg::RECIP_625);
        quot  = qprod[48:spdd_pkg::RECIP_SHIFT];
        qs    = map.prod_neg ? $signed(-16'(quot)) : $signed(16'(quot));
        mapped = $signed({2'b00, cfg.pulse_low}) + qs;
        if (map.dead) begin
            mapped = $signed({2'b00, map.stick_neg ? cfg.edge_below : cfg.edge_above});
        end
        pos    = mapped[15] ? 16'd0 : 16'(mapped);
        target = DUTY_BITS'(spdd_pkg::sat16(pos, DMAX));
    end

endmodule

// ----- design/spdd_state.sv -----
// Channel state: targets, dither fractions, pin duties, dither counter and
// watchdog, with the per-transaction update. Depends on spdd_pkg.
module spdd_state #(
    parameter int DUTY_BITS = spdd_pkg::DUTY_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  upd,
    input  spdd_pkg::map_t        map,
    input  logic [DUTY_BITS-1:0]  new_target,
    input  spdd_pkg::cfg_t        cfg,
    output spdd_pkg::res_t        res
);

    localparam int          NCH  = spdd_pkg::NCH;
    localparam int          EW   = DUTY_BITS + spdd_pkg::PW;
    localparam logic [15:0] DMAX = 16'((32'd1 << DUTY_BITS) - 32'd1);
    localparam logic [DUTY_BITS-1:0] RST_TARGET =
        DUTY_BITS'(spdd_pkg::sat16(16'(spdd_pkg::RST_PULSE_MIDDLE), DMAX));

    logic [DUTY_BITS-1:0] target_reg [NCH];
    logic [DUTY_BITS-1:0] target_next[NCH];
    logic [9:0]           frac_reg   [NCH];
    logic [9:0]           frac_next  [NCH];
    logic [DUTY_BITS-1:0] duty_reg   [NCH];
    logic [DUTY_BITS-1:0] duty_next  [NCH];
    logic [5:0]           cnt_reg;
    logic [5:0]           cnt_next;
    logic [31:0]          wd_reg;
    logic [31:0]          wd_next;

    logic                 expired;
    logic                 is_auto;
    logic [DUTY_BITS-1:0] mid_sat;
    logic [15:0]          cnt_k;
    logic [15:0]          frac_k [NCH];
    logic [6:0]           cnt_inc;
    logic [EW-1:0]        ext    [NCH];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            target_next[c] = target_reg[c];
            frac_next[c]   = frac_reg[c];
            duty_next[c]   = duty_reg[c];
            frac_k[c]      = 16'(frac_reg[c]) * 16'(cfg.dither_span);
        end
        cnt_next = cnt_reg;
        wd_next  = wd_reg;
        expired  = 1'b0;
        mid_sat  = DUTY_BITS'(spdd_pkg::sat16(16'(cfg.pulse_middle), DMAX));
        is_auto  = cfg.auto_mask[map.channel];
        cnt_k    = 16'(cnt_reg) * 16'(spdd_pkg::FRAC_ONE);
        cnt_inc  = 7'(cnt_reg) + 7'd1;

        case (map.opcode)
            spdd_pkg::OP_AUTO: begin
                if (is_auto) begin
                    target_next[map.channel] = new_target;
                    frac_next[map.channel]   = map.frac;
                end
            end
            spdd_pkg::OP_RX: begin
                if (!is_auto) begin
                    target_next[map.channel] = new_target;
                    frac_next[map.channel]   = map.frac;
                end
            end
            spdd_pkg::OP_TICK: begin
                if (wd_reg != 32'd0) begin
                    wd_next = wd_reg - 32'd1;
                    if (wd_reg == 32'd1) begin
                        expired = 1'b1;
                        for (int c = 0; c < NCH; c++) begin
                            target_next[c] = mid_sat;
                            if (cfg.auto_mask[c]) begin
                                duty_next[c] = mid_sat;
                            end
                        end
                    end else begin
                        for (int c = 0; c < NCH; c++) begin
                            if (cnt_reg == 6'd0) begin
                                duty_next[c] = target_reg[c];
                            end
                            if (cnt_k > frac_k[c]) begin
                                duty_next[c] = mid_sat;
                            end
                        end
                        cnt_next = (cnt_inc > {1'b0, cfg.dither_span}) ? 6'd0 : cnt_inc[5:0];
                    end
                end
            end
            spdd_pkg::OP_LOAD: begin
                wd_next = map.timeout_value;
            end
            default: begin
            end
        endcase

        for (int c = 0; c < NCH; c++) begin
            ext[c]      = EW'(duty_next[c]);
            res.duty[c] = ext[c][spdd_pkg::PW-1:0];
        end
        res.ticks_left = wd_next;
        res.expired    = expired;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NCH; c++) begin
                target_reg[c] <= RST_TARGET;
                frac_reg[c]   <= 10'd0;
                duty_reg[c]   <= '0;
            end
            cnt_reg <= 6'd0;
            wd_reg  <= 32'd0;
        end else if (upd) begin
            for (int c = 0; c < NCH; c++) begin
                target_reg[c] <= target_next[c];
                frac_reg[c]   <= frac_next[c];
                duty_reg[c]   <= duty_next[c];
            end
            cnt_reg <= cnt_next;
            wd_reg  <= wd_next;
        end
    end

endmodule

// ----- design/stick_pulse_deadzone_dither_top.sv -----
// Top level of the four-channel stick pulse driver with deadzone dither and watchdog.
// Depends on spdd_pkg, spdd_stick_map, spdd_target_calc and spdd_state.
//
// Usage:
//   Input stream (s_): one transaction per command. s_tuser carries the opcode
//   (auto command, receiver sample, one-millisecond tick, load timeout) and the
//   channel; s_tdata carries the stick value and the timeout value.
//   Output stream (m_): exactly one transaction per input transaction, in order,
//   holding the four pin duties after the update, the watchdog count and the
//   expiry flag.
//   Configuration: cfg_wr_en with cfg_addr/cfg_wdata writes one register per
//   cycle; write only while no transaction is in flight.
// Timing:
//   The path from input to output runs through the input register, product register
//   and result register. Throughput is one transaction per cycle while m_tready
//   is high; the product of the stick mapping is registered before the reciprocal
//   divide, and all state is updated in the stage that loads the result register.
// Reset: aresetn low clears the pipeline, restores the default registers,
//   sets targets to the middle pulse and duties, counter and watchdog to zero.
// Stall: with m_tready low the result is held; s_tready stays high while a
//   pipeline stage is free, so up to two more transactions are taken.
module stick_pulse_deadzone_dither_top #(
    parameter int DUTY_BITS = spdd_pkg::DUTY_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // stick_value[15:0], timeout_value[47:16]
    input  logic [3:0]  s_tuser,   // opcode[1:0], channel[3:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    // duty_roll[13:0], duty_pitch[27:14], duty_yaw[41:28], duty_gaz[55:42],
    // ticks_left[87:56], expired[88], zero fill[95:89]
    output logic [95:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [13:0] cfg_wdata
);

    spdd_pkg::cfg_t  cfg_reg;
    spdd_pkg::item_t item_reg;
    spdd_pkg::map_t  map_comb;
    spdd_pkg::map_t  map_reg;
    spdd_pkg::res_t  res_comb;
    spdd_pkg::res_t  res_reg;

    logic                 v1_reg;
    logic                 v2_reg;
    logic                 out_v_reg;
    logic                 adv1;
    logic                 adv2;
    logic                 adv_out;
    logic                 upd;
    logic [DUTY_BITS-1:0] new_target;

    assign adv_out  = !out_v_reg || m_tready;
    assign adv2     = !v2_reg || adv_out;
    assign adv1     = !v1_reg || adv2;
    assign upd      = v2_reg && adv_out;
    assign s_tready = adv1;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = 96'(res_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.auto_mask    <= 4'd0;
            cfg_reg.pulse_low    <= spdd_pkg::RST_PULSE_LOW;
            cfg_reg.pulse_high   <= spdd_pkg::RST_PULSE_HIGH;
            cfg_reg.pulse_middle <= spdd_pkg::RST_PULSE_MIDDLE;
            cfg_reg.edge_above   <= spdd_pkg::RST_EDGE_ABOVE;
            cfg_reg.edge_below   <= spdd_pkg::RST_EDGE_BELOW;
            cfg_reg.dither_span  <= spdd_pkg::RST_DITHER_SPAN;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                spdd_pkg::REG_AUTO_MASK:    cfg_reg.auto_mask    <= cfg_wdata[3:0];
                spdd_pkg::REG_PULSE_LOW:    cfg_reg.pulse_low    <= cfg_wdata;
                spdd_pkg::REG_PULSE_HIGH:   cfg_reg.pulse_high   <= cfg_wdata;
                spdd_pkg::REG_PULSE_MIDDLE: cfg_reg.pulse_middle <= cfg_wdata;
                spdd_pkg::REG_EDGE_ABOVE:   cfg_reg.edge_above   <= cfg_wdata;
                spdd_pkg::REG_EDGE_BELOW:   cfg_reg.edge_below   <= cfg_wdata;
                spdd_pkg::REG_DITHER_SPAN:  cfg_reg.dither_span  <= cfg_wdata[5:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_tvalid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv_out) begin
                out_v_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && s_tvalid) begin
            item_reg.opcode        <= s_tuser[1:0];
            item_reg.channel       <= s_tuser[3:2];
            item_reg.stick_value   <= s_tdata[15:0];
            item_reg.timeout_value <= s_tdata[47:16];
        end
        if (adv2 && v1_reg) begin
            map_reg <= map_comb;
        end
        if (upd) begin
            res_reg <= res_comb;
        end
    end

    spdd_stick_map u_map (
        .item (item_reg),
        .cfg  (cfg_reg),
        .map  (map_comb)
    );

    spdd_target_calc #(
        .DUTY_BITS (DUTY_BITS)
    ) u_calc (
        .map    (map_reg),
        .cfg    (cfg_reg),
        .target (new_target)
    );

    spdd_state #(
        .DUTY_BITS (DUTY_BITS)
    ) u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .upd        (upd),
        .map        (map_reg),
        .new_target (new_target),
        .cfg        (cfg_reg),
        .res        (res_comb)
    );

    a_expired_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && res_reg.expired |-> res_reg.ticks_left == 32'd0)
        else $error("expiry reported with watchdog count nonzero");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !adv_out |=> v2_reg && $stable(map_reg))
        else $error("stalled product stage lost its transaction");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !v1_reg && !v2_reg && !out_v_reg)
        else $error("pipeline not empty after reset");

endmodule
